FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the keyed last-value store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/klvms_pkg.sv
// Package with the sizes, opcodes and entry type of the keyed last-value store.
package klvms_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 24;
  localparam int CHAN_W      = 4;
  localparam int VAL_W       = 14;
  localparam int OP_W        = 2;

  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_REPLAY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CHAN_W-1:0] chan;
    logic [VAL_W-1:0]  val;
  } entry_t;

endpackage

FILE: sv/keyed_last_value_macro_store_unit.sv
// Keyed last-value message store: ordered table with record, replay and clear.
//
// The input channel (in_valid, in_stall) takes one command beat: record, replay
// or clear. The result channel (out_valid, out_stall) carries one beat for each
// replayed table entry, in insertion order, with out_last_entry on the final one.
// cfg_we with cfg_wdata writes the record enable bit; the user must write it only
// while idle, as the block does not enforce this. A record on a non-empty table
// scans the stored keys through the table memory, one entry per cycle, and holds
// in_stall high until an entry matches or the last one is compared. A record into
// an empty table is written at once, with no stall. A replay streams one entry
// per cycle while the receiver does not stall, and holds the input until every
// entry has been read out. Clear, a disabled record and the unused opcode
// complete with no stall. When the receiver stalls, the output register holds
// its beat and the read pipeline pauses behind it; a new command may be taken
// while the last result still waits. Reset clears the entry count, the overflow
// flag, the record enable and all handshakes; the table memory is not cleared.
module keyed_last_value_macro_store_unit
  import klvms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [ADDR_W-1:0] in_control_address,
  input  logic [CHAN_W-1:0] in_channel,
  input  logic [VAL_W-1:0]  in_message_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] out_address,
  output logic [CHAN_W-1:0] out_channel,
  output logic [VAL_W-1:0]  out_value,
  output logic              out_last_entry,
  output logic              out_overflowed
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPLAY
  } state_t;

  state_t            state_r, state_nxt;
  logic              rec_en_r, rec_en_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  issue_idx_r, issue_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic              out_valid_r, out_valid_nxt;

  entry_t            item_r;
  entry_t            rd_data_r;
  entry_t            out_entry_r;
  logic              out_last_r;
  logic              out_ovf_r;

  entry_t            entry_mem [TABLE_DEPTH];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;

  logic              accept;
  logic              out_load;
  logic              key_hit;
  logic [CNT_W-1:0]  last_cnt;
  logic              room;

  assign in_stall       = (state_r != ST_IDLE);
  assign accept         = in_valid && !in_stall;
  assign out_load       = pend_vld_r && (!out_valid_r || !out_stall);
  assign last_cnt       = count_r - CNT_W'(1);
  assign room           = (count_r < CNT_W'(TABLE_DEPTH));
  assign key_hit        = (rd_data_r.addr == item_r.addr) && (rd_data_r.chan == item_r.chan);
  assign mem_raddr      = issue_idx_r[IDX_W-1:0];

  assign out_valid      = out_valid_r;
  assign out_address    = out_entry_r.addr;
  assign out_channel    = out_entry_r.chan;
  assign out_value      = out_entry_r.val;
  assign out_last_entry = out_last_r;
  assign out_overflowed = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    rec_en_nxt    = cfg_we ? cfg_wdata : rec_en_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    issue_idx_nxt = issue_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    pend_vld_nxt  = pend_vld_r && !out_load;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_load || (out_valid_r && out_stall);
    mem_we        = 1'b0;
    mem_waddr     = count_r[IDX_W-1:0];
    mem_wdata     = item_r;
    mem_re        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_RECORD: begin
              if (rec_en_r) begin
                if (count_r == '0) begin
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = '{addr: in_control_address, chan: in_channel,
                                val: in_message_value};
                  count_nxt = CNT_W'(1);
                end else begin
                  state_nxt     = ST_SCAN;
                  issue_idx_nxt = '0;
                end
              end
            end
            OP_REPLAY: begin
              if (count_r != '0) begin
                state_nxt     = ST_REPLAY;
                issue_idx_nxt = '0;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (issue_idx_r < count_r) begin
          mem_re        = 1'b1;
          issue_idx_nxt = issue_idx_r + CNT_W'(1);
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = issue_idx_r[IDX_W-1:0];
        end
        if (cmp_vld_r && key_hit) begin
          mem_we      = 1'b1;
          mem_waddr   = cmp_idx_r;
          state_nxt   = ST_IDLE;
          cmp_vld_nxt = 1'b0;
        end else if (cmp_vld_r && (cmp_idx_r == last_cnt[IDX_W-1:0])) begin
          if (room) begin
            mem_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          state_nxt   = ST_IDLE;
          cmp_vld_nxt = 1'b0;
        end
      end

      ST_REPLAY: begin
        if ((issue_idx_r < count_r) && (!pend_vld_r || out_load)) begin
          mem_re        = 1'b1;
          issue_idx_nxt = issue_idx_r + CNT_W'(1);
          pend_vld_nxt  = 1'b1;
          pend_last_nxt = (issue_idx_r == last_cnt);
        end else if ((issue_idx_r == count_r) && !pend_vld_r) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rec_en_r    <= 1'b0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      issue_idx_r <= '0;
      cmp_vld_r   <= 1'b0;
      cmp_idx_r   <= '0;
      pend_vld_r  <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rec_en_r    <= rec_en_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      issue_idx_r <= issue_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      pend_vld_r  <= pend_vld_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      item_r <= '{addr: in_control_address, chan: in_channel, val: in_message_value};
    end
    if (out_load) begin
      out_entry_r <= rd_data_r;
      out_last_r  <= pend_last_r;
      out_ovf_r   <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= entry_mem[mem_raddr];
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(TABLE_DEPTH))
  `ASSERT_IMPL(a_pend_in_replay, pend_vld_r, state_r == ST_REPLAY)
  `ASSERT_IMPL(a_cmp_in_scan, cmp_vld_r, state_r == ST_SCAN)
  `ASSERT_IMPL(a_no_write_in_replay, mem_we, state_r != ST_REPLAY)
  `ASSERT_NEXT(a_scan_leaves_idle, accept && (in_opcode == OP_RECORD) && rec_en_r
               && (count_r != '0), state_r == ST_SCAN)

endmodule
